>>> sv/nvme_read_command_builder_core_assert.svh
// Assertion helpers for the RTL files; nvrcb_seq.sv includes them.
`ifndef NVME_READ_COMMAND_BUILDER_CORE_ASSERT_SVH
`define NVME_READ_COMMAND_BUILDER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset
`define NVRCB_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("nvrcb assertion failed");

// Next-cycle implication, checked on every clock edge outside reset
`define NVRCB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("nvrcb assertion failed");

`endif

>>> sv/nvrcb_pkg.sv
package nvrcb_pkg;

   // Field and datapath widths
   localparam int ADDR_W       = 48;
   localparam int ALU_W        = ADDR_W + 1;
   localparam int COUNT_W      = 16;
   localparam int SECTOR_SHIFT = 9;
   localparam int MAX_LIST     = 16;
   localparam int ENTRY_W      = $clog2(MAX_LIST + 1);
   localparam int LIST_IDX_W   = 4;
   localparam int CMD_ID_W     = 16;
   localparam int SLOT_W       = 4;
   localparam int BLOCKS_W     = 7;
   localparam int CSR_IDX_W    = 2;

   // Parameter defaults
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int MAX_SECTORS_DEF = 128;
   localparam int PAGE_BYTES_DEF  = 4096;

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_DEVICE_READY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NAMESPACE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIST_BASE    = 2'd2;

   typedef enum logic [1:0] {
      KIND_LIST = 2'd0,
      KIND_CMD  = 2'd1,
      KIND_REJ  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE        = 3'd0,
      ERR_NOT_READY   = 3'd1,
      ERR_NULL_BUFFER = 3'd2,
      ERR_BAD_COUNT   = 3'd3,
      ERR_RANGE       = 3'd4,
      ERR_WRAP        = 3'd5
   } err_type;

   typedef struct packed {
      logic              device_ready;
      logic [ADDR_W-1:0] namespace_sectors;
      logic [ADDR_W-1:0] prp_list_base;
   } cfg_type;

   typedef struct packed {
      logic [ALU_W-1:0] op_a;
      logic [ALU_W-1:0] op_b;
      logic             carry_in;
   } alu_req_type;

   typedef struct packed {
      kind_type              kind;
      logic [LIST_IDX_W-1:0] list_index;
      logic [ADDR_W-1:0]     list_address;
      logic [CMD_ID_W-1:0]   command_id;
      logic [SLOT_W-1:0]     sq_slot;
      logic [ADDR_W-1:0]     cmd_block;
      logic [BLOCKS_W-1:0]   blocks_minus_one;
      logic [ADDR_W-1:0]     prp_first;
      logic [ADDR_W-1:0]     prp_second;
      err_type               error_code;
      logic                  last;
   } rsp_type;

endpackage

>>> sv/nvrcb_alu.sv
module nvrcb_alu (
   input  nvrcb_pkg::alu_req_type          alu_req,
   output logic [nvrcb_pkg::ALU_W-1:0]     alu_sum
);

   // Shared add / subtract unit, subtraction by inverted operand and carry in
   assign alu_sum = alu_req.op_a + alu_req.op_b
                    + {{(nvrcb_pkg::ALU_W-1){1'b0}}, alu_req.carry_in};

endmodule

>>> sv/nvrcb_seq.sv
`include "nvme_read_command_builder_core_assert.svh"

module nvrcb_seq #(
   parameter int MAX_SECTORS = nvrcb_pkg::MAX_SECTORS_DEF,
   parameter int PAGE_BYTES  = nvrcb_pkg::PAGE_BYTES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  nvrcb_pkg::cfg_type                 cfg,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [nvrcb_pkg::ADDR_W-1:0]       start_block,
   input  logic [nvrcb_pkg::COUNT_W-1:0]      sector_total,
   input  logic [nvrcb_pkg::ADDR_W-1:0]       buffer_address,
   input  logic [nvrcb_pkg::CMD_ID_W-1:0]     command_id,
   input  logic [nvrcb_pkg::SLOT_W-1:0]       sq_slot,
   output logic                               cmd_adv,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output nvrcb_pkg::rsp_type                 rsp
);

   localparam int AW         = nvrcb_pkg::ALU_W;
   localparam int DW         = nvrcb_pkg::ADDR_W;
   localparam int EW         = nvrcb_pkg::ENTRY_W;
   localparam int IW         = nvrcb_pkg::LIST_IDX_W;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b00_0000_0001,
      S_CHK0   = 10'b00_0000_0010,
      S_CHK1   = 10'b00_0000_0100,
      S_CHK2   = 10'b00_0000_1000,
      S_CHK3   = 10'b00_0001_0000,
      S_CHK4   = 10'b00_0010_0000,
      S_SECOND = 10'b00_0100_0000,
      S_LIST   = 10'b00_1000_0000,
      S_CMD    = 10'b01_0000_0000,
      S_REJ    = 10'b10_0000_0000
   } state_type;

   state_type                        state_ff, state_in;
   logic [DW-1:0]                    lba_ff, lba_in;
   logic [nvrcb_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic [DW-1:0]                    buf_ff, buf_in;
   logic [DW-1:0]                    span_ff, span_in;
   logic [EW-1:0]                    entries_ff, entries_in;
   logic [IW-1:0]                    idx_ff, idx_in;
   logic [DW-1:0]                    addr_ff, addr_in;
   logic [DW-1:0]                    second_ff, second_in;
   nvrcb_pkg::err_type               err_ff, err_in;
   nvrcb_pkg::rsp_type               rsp_ff, rsp_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   nvrcb_pkg::alu_req_type           alu_req;
   logic [AW-1:0]                    alu_sum;
   logic                             out_free;
   logic                             count_bad;

   nvrcb_alu u_alu (
      .alu_req (alu_req),
      .alu_sum (alu_sum)
   );

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_tready = (state_ff == S_IDLE);
   assign cmd_adv    = (state_ff == S_CMD) && out_free;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp        = rsp_ff;
   assign count_bad  = (count_ff == '0)
                       || (count_ff > nvrcb_pkg::COUNT_W'(MAX_SECTORS));

   // Steer the shared adder by sequencer step
   always_comb begin
      alu_req = '0;
      case (state_ff)
         S_CHK0: begin
            alu_req.op_a     = {1'b0, cfg.namespace_sectors};
            alu_req.op_b     = ~{1'b0, lba_ff};
            alu_req.carry_in = 1'b1;
         end
         S_CHK1: begin
            alu_req.op_a     = {1'b0, span_ff};
            alu_req.op_b     = ~AW'(count_ff);
            alu_req.carry_in = 1'b1;
         end
         S_CHK2: begin
            alu_req.op_a     = {1'b0, buf_ff};
            alu_req.op_b     = AW'({count_ff, {nvrcb_pkg::SECTOR_SHIFT{1'b0}}});
         end
         S_CHK3: begin
            alu_req.op_a     = {1'b0, span_ff};
            alu_req.op_b     = '1;
         end
         S_CHK4: begin
            alu_req.op_a     = AW'(span_ff[DW-1:PAGE_SHIFT]);
            alu_req.op_b     = ~AW'(buf_ff[DW-1:PAGE_SHIFT]);
            alu_req.carry_in = 1'b1;
         end
         S_SECOND, S_LIST: begin
            alu_req.op_a     = {1'b0, addr_ff};
            alu_req.op_b     = AW'(PAGE_BYTES);
         end
         default: begin
            alu_req = '0;
         end
      endcase
   end

   // Sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      lba_in       = lba_ff;
      count_in     = count_ff;
      buf_in       = buf_ff;
      span_in      = span_ff;
      entries_in   = entries_ff;
      idx_in       = idx_ff;
      addr_in      = addr_ff;
      second_in    = second_ff;
      err_in       = err_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      // Drop the result once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               lba_in   = start_block;
               count_in = sector_total;
               buf_in   = buffer_address;
               state_in = S_CHK0;
            end
         end
         // Cheap checks, then namespace minus start block
         S_CHK0: begin
            span_in = alu_sum[DW-1:0];
            if (!cfg.device_ready) begin
               err_in   = nvrcb_pkg::ERR_NOT_READY;
               state_in = S_REJ;
            end else if (buf_ff == '0) begin
               err_in   = nvrcb_pkg::ERR_NULL_BUFFER;
               state_in = S_REJ;
            end else if (count_bad) begin
               err_in   = nvrcb_pkg::ERR_BAD_COUNT;
               state_in = S_REJ;
            end else if (alu_sum[AW-1] || (alu_sum == '0)) begin
               err_in   = nvrcb_pkg::ERR_RANGE;
               state_in = S_REJ;
            end else begin
               state_in = S_CHK1;
            end
         end
         // Count must fit in what is left of the namespace
         S_CHK1: begin
            if (alu_sum[AW-1]) begin
               err_in   = nvrcb_pkg::ERR_RANGE;
               state_in = S_REJ;
            end else begin
               state_in = S_CHK2;
            end
         end
         // Buffer end must stay below the top of the address space
         S_CHK2: begin
            span_in = alu_sum[DW-1:0];
            if (alu_sum[AW-1]) begin
               err_in   = nvrcb_pkg::ERR_WRAP;
               state_in = S_REJ;
            end else begin
               state_in = S_CHK3;
            end
         end
         // Last byte address
         S_CHK3: begin
            span_in  = alu_sum[DW-1:0];
            addr_in  = {buf_ff[DW-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
            state_in = S_CHK4;
         end
         // Page count minus one gives the list entries
         S_CHK4: begin
            entries_in = alu_sum[EW-1:0];
            idx_in     = '0;
            second_in  = '0;
            if (alu_sum > AW'(nvrcb_pkg::MAX_LIST)) begin
               err_in   = nvrcb_pkg::ERR_BAD_COUNT;
               state_in = S_REJ;
            end else if (alu_sum == '0) begin
               state_in = S_CMD;
            end else if (alu_sum == AW'(1)) begin
               state_in = S_SECOND;
            end else begin
               state_in = S_LIST;
            end
         end
         S_SECOND: begin
            second_in = alu_sum[DW-1:0];
            state_in  = S_CMD;
         end
         // One list entry per following page
         S_LIST: begin
            if (out_free) begin
               rsp_in              = '0;
               rsp_in.kind         = nvrcb_pkg::KIND_LIST;
               rsp_in.list_index   = idx_ff;
               rsp_in.list_address = alu_sum[DW-1:0];
               rsp_valid_in        = 1'b1;
               addr_in             = alu_sum[DW-1:0];
               idx_in              = idx_ff + 1'b1;
               if (EW'(idx_ff) == entries_ff - 1'b1) begin
                  second_in = cfg.prp_list_base;
                  state_in  = S_CMD;
               end
            end
         end
         S_CMD: begin
            if (out_free) begin
               rsp_in                  = '0;
               rsp_in.kind             = nvrcb_pkg::KIND_CMD;
               rsp_in.command_id       = command_id;
               rsp_in.sq_slot          = sq_slot;
               rsp_in.cmd_block        = lba_ff;
               rsp_in.blocks_minus_one = nvrcb_pkg::BLOCKS_W'(count_ff - 1'b1);
               rsp_in.prp_first        = buf_ff;
               rsp_in.prp_second       = second_ff;
               rsp_in.error_code       = nvrcb_pkg::ERR_NONE;
               rsp_in.last             = 1'b1;
               rsp_valid_in            = 1'b1;
               state_in                = S_IDLE;
            end
         end
         S_REJ: begin
            if (out_free) begin
               rsp_in            = '0;
               rsp_in.kind       = nvrcb_pkg::KIND_REJ;
               rsp_in.error_code = err_ff;
               rsp_in.last       = 1'b1;
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      lba_ff     <= lba_in;
      count_ff   <= count_in;
      buf_ff     <= buf_in;
      span_ff    <= span_in;
      entries_ff <= entries_in;
      idx_ff     <= idx_in;
      addr_ff    <= addr_in;
      second_ff  <= second_in;
      err_ff     <= err_in;
      rsp_ff     <= rsp_in;
   end

   `NVRCB_ASSERT_IMPL(a_list_not_last, rsp_valid_ff && (rsp_ff.kind == nvrcb_pkg::KIND_LIST), !rsp_ff.last)
   `NVRCB_ASSERT_NEXT(a_accept_checks, req_tvalid && req_tready, state_ff == S_CHK0)
   `NVRCB_ASSERT_NEXT(a_adv_cmd, cmd_adv, rsp_valid_ff && (rsp_ff.kind == nvrcb_pkg::KIND_CMD) && rsp_ff.last)

endmodule

>>> sv/nvme_read_command_builder_core.sv
// Channel   Ports                          Contents
// request   req_tvalid/tready/tdata        one read request
// result    rsp_tvalid/tready/tdata/tuser  list entries, then command or rejection
//           rsp_tlast                      set on the final result of a request
// config    csr_valid/ready/index/data     register writes, always ready
//
// A request runs through up to five check steps on one shared 49-bit adder,
// then emits its PRP list entries one by one (the same adder steps the page
// address), then the command. A rejection skips the remaining checks and
// leaves through the reject step. req_tready is high only while the sequencer
// is idle; the last result may still wait in the output register. A stalled
// result holds the sequencer at its emit step.
// Reset is synchronous: command id returns to one, queue tail to zero.
module nvme_read_command_builder_core #(
   parameter int QUEUE_DEPTH = nvrcb_pkg::QUEUE_DEPTH_DEF,
   parameter int MAX_SECTORS = nvrcb_pkg::MAX_SECTORS_DEF,
   parameter int PAGE_BYTES  = nvrcb_pkg::PAGE_BYTES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // start_block[47:0], sector_total[63:48], buffer_address[111:64]
   input  logic [111:0]                        req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // list_index[3:0], list_address[51:4], command_id[67:52], sq_slot[71:68],
   // cmd_block[119:72], blocks_minus_one[126:120], prp_first[174:127],
   // prp_second[222:175], error_code[225:223], zero fill[231:226]
   output logic [231:0]                        rsp_tdata,
   // kind[1:0]
   output logic [1:0]                          rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [nvrcb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [nvrcb_pkg::ADDR_W-1:0]        csr_data
);

   localparam int TAIL_W = $clog2(QUEUE_DEPTH);

   nvrcb_pkg::cfg_type                cfg_ff, cfg_in;
   logic [nvrcb_pkg::CMD_ID_W-1:0]    cmd_id_ff, cmd_id_in;
   logic [TAIL_W-1:0]                 tail_ff, tail_in;
   logic                              cmd_adv;
   logic                              rsp_valid;
   nvrcb_pkg::rsp_type                rsp;

   assign csr_ready = 1'b1;

   // Register writes; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            nvrcb_pkg::CSR_DEVICE_READY: cfg_in.device_ready      = csr_data[0];
            nvrcb_pkg::CSR_NAMESPACE:    cfg_in.namespace_sectors = csr_data;
            nvrcb_pkg::CSR_LIST_BASE:    cfg_in.prp_list_base     = csr_data;
            default:                     cfg_in                   = cfg_ff;
         endcase
      end
   end

   // Advance command id and queue tail on each issued command
   always_comb begin
      cmd_id_in = cmd_id_ff;
      tail_in   = tail_ff;
      if (cmd_adv) begin
         cmd_id_in = cmd_id_ff + 1'b1;
         if (tail_ff == TAIL_W'(QUEUE_DEPTH - 1)) begin
            tail_in = '0;
         end else begin
            tail_in = tail_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff    <= '0;
         cmd_id_ff <= nvrcb_pkg::CMD_ID_W'(1);
         tail_ff   <= '0;
      end else begin
         cfg_ff    <= cfg_in;
         cmd_id_ff <= cmd_id_in;
         tail_ff   <= tail_in;
      end
   end

   nvrcb_seq #(
      .MAX_SECTORS (MAX_SECTORS),
      .PAGE_BYTES  (PAGE_BYTES)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .start_block    (req_tdata[47:0]),
      .sector_total   (req_tdata[63:48]),
      .buffer_address (req_tdata[111:64]),
      .command_id     (cmd_id_ff),
      .sq_slot        (nvrcb_pkg::SLOT_W'(tail_ff)),
      .cmd_adv        (cmd_adv),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_tready),
      .rsp            (rsp)
   );

   // Pack the result
   assign rsp_tvalid = rsp_valid;
   assign rsp_tuser  = rsp.kind;
   assign rsp_tlast  = rsp.last;
   assign rsp_tdata  = {6'd0, rsp.error_code, rsp.prp_second, rsp.prp_first,
                        rsp.blocks_minus_one, rsp.cmd_block, rsp.sq_slot,
                        rsp.command_id, rsp.list_address, rsp.list_index};

endmodule
